// ===== rtl/core/psr_pkg.sv =====
// Shared constants for the pixel square root pipeline.
`timescale 1ns / 1ps

package psr_pkg;

  localparam int PIXEL_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 8;
  localparam int ROOT_OUT_W     = 16;

  localparam logic MODE_INT  = 1'b0;
  localparam logic MODE_FRAC = 1'b1;

  localparam logic [ROOT_OUT_W-1:0] ROOT_SAT = '1;

endpackage

// ===== rtl/core/pixel_square_root.sv =====
// Top level: pipelined digit-by-digit square root of signed pixels.
// Pipeline: one input register, then one register stage per root bit.
// Throughput: one request per cycle; the whole pipeline holds while a result waits.
// Reset: rst_n low synchronously empties the pipeline and sets output_mode to 0.
`timescale 1ns / 1ps

module pixel_square_root #(
  parameter int PIXEL_BITS = psr_pkg::PIXEL_BITS_DEF,
  parameter int FRAC_BITS  = psr_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic                                cfg_wr_data,   // output_mode
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [((PIXEL_BITS+7)/8)*8-1:0]     in_tdata,      // pixel
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [psr_pkg::ROOT_OUT_W-1:0]      out_tdata,     // root
  output logic                                out_tuser      // clamped
);

  localparam int ROOT_W = (PIXEL_BITS + 2 * FRAC_BITS) / 2;
  localparam int RAD_W  = 2 * ROOT_W;
  localparam int REM_W  = ROOT_W + 2;

  logic                output_mode_r;
  logic                en;
  logic                neg;
  logic [RAD_W-1:0]    mag;
  logic [RAD_W-1:0]    rad_in;

  logic [ROOT_W:0]     vld_r;
  logic [ROOT_W:0]     clamp_r;
  logic [RAD_W-1:0]    rad_r  [0:ROOT_W];
  logic [REM_W-1:0]    rem_r  [0:ROOT_W];
  logic [ROOT_W-1:0]   root_r [0:ROOT_W];

  logic [RAD_W-1:0]    rad_nxt  [1:ROOT_W];
  logic [REM_W-1:0]    rem_nxt  [1:ROOT_W];
  logic [ROOT_W-1:0]   root_nxt [1:ROOT_W];
  logic [REM_W-1:0]    rem_sh   [0:ROOT_W-1];
  logic [REM_W-1:0]    trial    [0:ROOT_W-1];
  logic [ROOT_W-1:0]   ge;

  assign en        = !(vld_r[ROOT_W] && !out_tready);
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      output_mode_r <= psr_pkg::MODE_INT;
    end else if (cfg_wr_en) begin
      output_mode_r <= cfg_wr_data;
    end
  end

  always_comb begin
    neg = in_tdata[PIXEL_BITS-1];
    mag = RAD_W'(in_tdata[PIXEL_BITS-2:0]);
    if (neg) begin
      rad_in = '0;
    end else if (output_mode_r == psr_pkg::MODE_FRAC) begin
      rad_in = mag << (2 * FRAC_BITS);
    end else begin
      rad_in = mag;
    end
  end

  always_comb begin
    for (int k = 0; k < ROOT_W; k++) begin
      rem_sh[k]       = {rem_r[k][REM_W-3:0], rad_r[k][RAD_W-1 -: 2]};
      trial[k]        = {root_r[k], 2'b01};
      ge[k]           = (rem_sh[k] >= trial[k]);
      rem_nxt[k+1]    = ge[k] ? (rem_sh[k] - trial[k]) : rem_sh[k];
      root_nxt[k+1]   = {root_r[k][ROOT_W-2:0], ge[k]};
      rad_nxt[k+1]    = rad_r[k] << 2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[ROOT_W-1:0], in_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      clamp_r   <= {clamp_r[ROOT_W-1:0], neg};
      rad_r[0]  <= rad_in;
      rem_r[0]  <= '0;
      root_r[0] <= '0;
      for (int k = 1; k <= ROOT_W; k++) begin
        rad_r[k]  <= rad_nxt[k];
        rem_r[k]  <= rem_nxt[k];
        root_r[k] <= root_nxt[k];
      end
    end
  end

  generate
    if (ROOT_W > psr_pkg::ROOT_OUT_W) begin : g_sat
      assign out_tdata = (|root_r[ROOT_W][ROOT_W-1:psr_pkg::ROOT_OUT_W]) ?
                         psr_pkg::ROOT_SAT :
                         root_r[ROOT_W][psr_pkg::ROOT_OUT_W-1:0];
    end else begin : g_nosat
      assign out_tdata = psr_pkg::ROOT_OUT_W'(root_r[ROOT_W]);
    end
  endgenerate

  assign out_tvalid = vld_r[ROOT_W];
  assign out_tuser  = clamp_r[ROOT_W];

endmodule

// ===== rtl/core/psr_checker.sv =====
// Port-level checker for the pixel square root, bound to the top level.
`timescale 1ns / 1ps

module psr_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tready,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [psr_pkg::ROOT_OUT_W-1:0] out_tdata,
  input logic                           out_tuser
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  a_clamp_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0)
    else $error("clamped result with nonzero root");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("input ready does not follow output stall");

endmodule

bind pixel_square_root psr_checker u_psr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// ===== bench/tb.sv =====
// Testbench for pixel_square_root: directed and random pixels with stalls on both sides.
`timescale 1ns / 1ps

module tb;

  localparam int PIXEL_W   = psr_pkg::PIXEL_BITS_DEF;
  localparam int DATA_W    = ((PIXEL_W + 7) / 8) * 8;
  localparam int LATENCY   = PIXEL_W / 2 + psr_pkg::FRAC_BITS_DEF + 1;
  localparam int MAX_WAIT  = 11;
  localparam int CYCLE_CAP = 400000;

  typedef struct packed {
    logic [psr_pkg::ROOT_OUT_W-1:0] root;
    logic                           clamped;
  } root_result_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           cfg_wr_en = 1'b0;
  logic                           cfg_wr_data = 1'b0;
  logic                           in_tvalid = 1'b0;
  logic                           in_tready;
  logic [DATA_W-1:0]              in_tdata = '0;
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [psr_pkg::ROOT_OUT_W-1:0] out_tdata;
  logic                           out_tuser;

  logic [DATA_W-1:0] pending_pixels [$];
  root_result_t      expected_roots [$];
  logic              output_mode_copy = psr_pkg::MODE_INT;
  int                in_wait = 0;
  int                out_wait = 0;
  bit                in_steady = 1'b0;
  bit                out_steady = 1'b0;
  int                errors = 0;
  int                cycles = 0;
  root_result_t      want;

  pixel_square_root dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic root_result_t square_root_of(logic [DATA_W-1:0] pixel, logic mode);
    root_result_t       res;
    longint unsigned    radicand;
    longint unsigned    trial;
    longint unsigned    acc;
    acc = 0;
    res.clamped = pixel[PIXEL_W-1];
    res.root = '0;
    if (!res.clamped) begin
      radicand = longint'(pixel[PIXEL_W-1:0]);
      if (mode == psr_pkg::MODE_FRAC)
        radicand = radicand << (2 * psr_pkg::FRAC_BITS_DEF);
      for (int b = 31; b >= 0; b--) begin
        trial = acc | (64'd1 << b);
        if (trial * trial <= radicand)
          acc = trial;
      end
      res.root = (acc > longint'(psr_pkg::ROOT_SAT)) ? psr_pkg::ROOT_SAT :
                 acc[psr_pkg::ROOT_OUT_W-1:0];
    end
    return res;
  endfunction

  task automatic report_mismatch(string what);
    $display("mismatch at cycle %0d: %s", cycles, what);
    errors++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready)
        expected_roots.push_back(square_root_of(in_tdata, output_mode_copy));
      if (!in_tvalid || in_tready) begin
        if (in_wait != 0) begin
          in_wait = in_wait - 1;
          in_tvalid <= 1'b0;
        end else if (pending_pixels.size() != 0) begin
          in_tdata <= pending_pixels.pop_front();
          in_tvalid <= 1'b1;
          if ($urandom_range(0, 63) == 0)
            in_steady = !in_steady;
          in_wait = in_steady ? 0 : $urandom_range(0, MAX_WAIT);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_roots.size() == 0) begin
          report_mismatch($sformatf("result root=%0d clamped=%0b with no request pending",
                                    out_tdata, out_tuser));
        end else begin
          want = expected_roots.pop_front();
          if (out_tdata !== want.root)
            report_mismatch($sformatf("root %0d, want %0d", out_tdata, want.root));
          if (out_tuser !== want.clamped)
            report_mismatch($sformatf("clamped %0b, want %0b", out_tuser, want.clamped));
        end
        if ($urandom_range(0, 63) == 0)
          out_steady = !out_steady;
        out_wait = out_steady ? 0 : $urandom_range(0, MAX_WAIT);
      end
      if (out_wait != 0) begin
        out_wait = out_wait - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic write_mode(logic mode);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= mode;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    output_mode_copy = mode;
  endtask

  task automatic load_directed();
    @(negedge clk);
    for (int k = 0; k <= 5; k++)
      pending_pixels.push_back(DATA_W'(k));
    pending_pixels.push_back(16'd15);
    pending_pixels.push_back(16'd16);
    pending_pixels.push_back(16'd17);
    pending_pixels.push_back(16'd255);
    pending_pixels.push_back(16'd256);
    pending_pixels.push_back(16'd16383);
    pending_pixels.push_back(16'd16384);
    pending_pixels.push_back(16'd32761);
    pending_pixels.push_back(16'd32766);
    pending_pixels.push_back(16'h7FFF);
    pending_pixels.push_back(16'hFFFF);
    pending_pixels.push_back(16'h8000);
    pending_pixels.push_back(16'h8001);
    pending_pixels.push_back(16'hC000);
    pending_pixels.push_back(16'h5555);
    pending_pixels.push_back(16'hAAAA);
  endtask

  task automatic load_random(int count);
    int k;
    @(negedge clk);
    repeat (count) begin
      case ($urandom_range(0, 3))
        0: pending_pixels.push_back(DATA_W'($urandom_range(0, 65535)));
        1: pending_pixels.push_back(DATA_W'($urandom_range(0, 400)));
        2: begin
          k = $urandom_range(0, 181);
          pending_pixels.push_back(DATA_W'(k * k + $urandom_range(0, 2) - 1));
        end
        default: pending_pixels.push_back(DATA_W'(16'h8000 | $urandom_range(0, 32767)));
      endcase
    end
  endtask

  task automatic drain();
    while (pending_pixels.size() != 0 || in_tvalid || expected_roots.size() != 0)
      @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    load_directed();
    drain();
    write_mode(psr_pkg::MODE_FRAC);
    load_directed();
    drain();
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 0)
        write_mode(psr_pkg::MODE_INT);
      else if (ph == 1)
        write_mode(psr_pkg::MODE_FRAC);
      else
        write_mode($urandom_range(0, 1) ? psr_pkg::MODE_FRAC : psr_pkg::MODE_INT);
      load_random(245);
      drain();
    end
    if (errors == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
